### hw/rtl/scrg_pkg.sv
// shared types, constants and helpers for the stratified camera ray generator
package scrg_pkg;

  localparam int MAX_GRID_SIDE_DEF = 8;
  localparam int CFG_DATA_W = 25;
  localparam int CFG_INDEX_W = 2;
  localparam int WORD_W = 64;
  localparam int MUL_STEPS = 32;
  localparam int DIV_STEPS = 48;
  localparam int ROOT_STEPS = 32;
  localparam int STEP_CNT_W = 6;
  localparam logic [63:0] HALF_Q24 = 64'd1 << 23;
  localparam logic [63:0] ONE_Q24 = 64'd1 << 24;
  localparam logic [63:0] ONE_Q32 = 64'd1 << 32;
  localparam logic [63:0] ROOT_BIT_INIT = 64'd1 << 62;
  localparam logic [29:0] D_LIMIT = 30'h3FFF_FFFF;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_TAN_HALF_FOV = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TWO_OVER_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_RATIO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_SIDE = 2'd3;

  typedef struct packed {
    logic [15:0] jitter_y;
    logic [15:0] jitter_x;
    logic [11:0] pixel_y;
    logic [11:0] pixel_x;
  } in_t;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic last_ray;
  } out_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_ROOT
  } op_t;

  typedef struct packed {
    logic start;
    op_t op;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } unit_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FY,
    ST_TY,
    ST_DY,
    ST_FX,
    ST_TX,
    ST_DX,
    ST_SQX,
    ST_SQY,
    ST_ROOT,
    ST_CX,
    ST_CY,
    ST_CZ,
    ST_EMIT
  } state_t;

  // signed Q1.15 component from a rounded quotient magnitude
  function automatic logic [15:0] unit_comp(input logic [63:0] m, input logic neg);
    logic [15:0] r;
    if (!neg) begin
      r = (m > 64'd32767) ? 16'd32767 : m[15:0];
    end else begin
      r = 16'(16'd0 - m[15:0]);
    end
    return r;
  endfunction

endpackage

### hw/rtl/stratified_camera_ray_generator.sv
// top level: sequencer, held pixel, configuration registers and output word register
// One pixel word yields n*n ray words (n = grid side, clamped to 1..MAX_GRID_SIDE), row by
// row. Each ray is worked out on a single shared multicycle unit under a small sequencer:
// five divides of 48 steps, six multiplies of 32 steps and one 32-step square root. Each
// operation is launched and awaited until the unit signals done; the emit state stalls
// while the output register still holds a ray not yet taken. The unit iterates one step
// per cycle. A finished ray waits in an output register while the next one is computed;
// the input is ready only while the sequencer is idle.
module stratified_camera_ray_generator #(
  parameter int MAX_GRID_SIDE = scrg_pkg::MAX_GRID_SIDE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  scrg_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output scrg_pkg::out_t                  out_data,
  input  logic                            cfg_write,
  input  logic [scrg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [scrg_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = (MAX_GRID_SIDE > 1) ? $clog2(MAX_GRID_SIDE) : 1;

  scrg_pkg::state_t state;
  scrg_pkg::state_t state_next;
  scrg_pkg::unit_req_t req;
  logic unit_busy;
  logic unit_done;
  logic [63:0] res;
  logic launched;

  logic [19:0] tan_half_fov;
  logic [24:0] two_over_height;
  logic [15:0] width_ratio;
  logic [3:0] grid_side;
  logic [3:0] n;

  scrg_pkg::in_t held_pixel;
  logic [CW-1:0] sub_row;
  logic [CW-1:0] sub_column;
  logic [63:0] work;
  logic [63:0] sq;
  logic [29:0] dx;
  logic [29:0] dy;
  logic nx;
  logic ny;
  logic [30:0] q;
  logic [15:0] cx;
  logic [15:0] cy;
  logic [15:0] cz;

  logic [63:0] t_rnd;
  logic [63:0] asp;
  logic [29:0] d_sat;
  logic row_end;
  logic col_end;

  // effective grid side
  always_comb begin
    if (grid_side == 4'd0) n = 4'd1;
    else if (grid_side > 4'(MAX_GRID_SIDE)) n = 4'(MAX_GRID_SIDE);
    else n = grid_side;
  end

  assign asp = 64'(width_ratio) << 12;
  assign t_rnd = (res + scrg_pkg::HALF_Q24) >> 24;
  assign d_sat = (t_rnd > 64'(scrg_pkg::D_LIMIT)) ? scrg_pkg::D_LIMIT : t_rnd[29:0];
  assign row_end = (4'(sub_row) == n - 4'd1);
  assign col_end = (4'(sub_column) == n - 4'd1);

  scrg_unit u_unit (
    .clk(clk),
    .rst(rst),
    .req(req),
    .busy(unit_busy),
    .done(unit_done),
    .result(res)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tan_half_fov <= 20'd65536;
      two_over_height <= 25'd65536;
      width_ratio <= 16'd4096;
      grid_side <= 4'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        scrg_pkg::REG_TAN_HALF_FOV: tan_half_fov <= cfg_data[19:0];
        scrg_pkg::REG_TWO_OVER_HEIGHT: two_over_height <= cfg_data;
        scrg_pkg::REG_WIDTH_RATIO: width_ratio <= cfg_data[15:0];
        scrg_pkg::REG_GRID_SIDE: grid_side <= cfg_data[3:0];
        default: grid_side <= grid_side;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      scrg_pkg::ST_IDLE: if (in_valid) state_next = scrg_pkg::ST_FY;
      scrg_pkg::ST_FY: if (unit_done) state_next = scrg_pkg::ST_TY;
      scrg_pkg::ST_TY: if (unit_done) state_next = scrg_pkg::ST_DY;
      scrg_pkg::ST_DY: if (unit_done) state_next = scrg_pkg::ST_FX;
      scrg_pkg::ST_FX: if (unit_done) state_next = scrg_pkg::ST_TX;
      scrg_pkg::ST_TX: if (unit_done) state_next = scrg_pkg::ST_DX;
      scrg_pkg::ST_DX: if (unit_done) state_next = scrg_pkg::ST_SQX;
      scrg_pkg::ST_SQX: if (unit_done) state_next = scrg_pkg::ST_SQY;
      scrg_pkg::ST_SQY: if (unit_done) state_next = scrg_pkg::ST_ROOT;
      scrg_pkg::ST_ROOT: if (unit_done) state_next = scrg_pkg::ST_CX;
      scrg_pkg::ST_CX: if (unit_done) state_next = scrg_pkg::ST_CY;
      scrg_pkg::ST_CY: if (unit_done) state_next = scrg_pkg::ST_CZ;
      scrg_pkg::ST_CZ: if (unit_done) state_next = scrg_pkg::ST_EMIT;
      scrg_pkg::ST_EMIT: begin
        if (!out_valid || out_ready) begin
          state_next = (row_end && col_end) ? scrg_pkg::ST_IDLE : scrg_pkg::ST_FY;
        end
      end
      default: state_next = scrg_pkg::ST_IDLE;
    endcase
  end

  // unit requests
  always_comb begin
    req.start = 1'b0;
    req.op = scrg_pkg::OP_MUL;
    req.a = '0;
    req.b = '0;
    in_ready = 1'b0;
    case (state)
      scrg_pkg::ST_IDLE: in_ready = 1'b1;
      scrg_pkg::ST_FY: begin
        req.op = scrg_pkg::OP_DIV;
        req.a = ((64'(sub_row) << 16) + 64'(held_pixel.jitter_y)) << 8;
        req.b = 64'(n);
      end
      scrg_pkg::ST_TY, scrg_pkg::ST_TX: begin
        req.a = work;
        req.b = 64'(two_over_height);
      end
      scrg_pkg::ST_DY, scrg_pkg::ST_DX: begin
        req.a = work;
        req.b = 64'(tan_half_fov);
      end
      scrg_pkg::ST_FX: begin
        req.op = scrg_pkg::OP_DIV;
        req.a = ((64'(sub_column) << 16) + 64'(held_pixel.jitter_x)) << 8;
        req.b = 64'(n);
      end
      scrg_pkg::ST_SQX: begin
        req.a = 64'(dx);
        req.b = 64'(dx);
      end
      scrg_pkg::ST_SQY: begin
        req.a = 64'(dy);
        req.b = 64'(dy);
      end
      scrg_pkg::ST_ROOT: begin
        req.op = scrg_pkg::OP_ROOT;
        req.a = sq;
      end
      scrg_pkg::ST_CX: begin
        req.op = scrg_pkg::OP_DIV;
        req.a = (64'(dx) << 15) + 64'(q[30:1]);
        req.b = 64'(q);
      end
      scrg_pkg::ST_CY: begin
        req.op = scrg_pkg::OP_DIV;
        req.a = (64'(dy) << 15) + 64'(q[30:1]);
        req.b = 64'(q);
      end
      scrg_pkg::ST_CZ: begin
        req.op = scrg_pkg::OP_DIV;
        req.a = (64'd1 << 31) + 64'(q[30:1]);
        req.b = 64'(q);
      end
      default: req.start = 1'b0;
    endcase
    if (state != scrg_pkg::ST_IDLE && state != scrg_pkg::ST_EMIT) begin
      req.start = !launched && !unit_busy;
    end
  end

  // sequencer control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scrg_pkg::ST_IDLE;
      launched <= 1'b0;
      sub_row <= '0;
      sub_column <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (req.start) launched <= 1'b1;
      else if (unit_done) launched <= 1'b0;
      if (state == scrg_pkg::ST_EMIT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
        if (col_end) begin
          sub_column <= '0;
          sub_row <= row_end ? '0 : sub_row + 1'b1;
        end else begin
          sub_column <= sub_column + 1'b1;
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath captures
  always_ff @(posedge clk) begin
    if (state == scrg_pkg::ST_IDLE && in_valid) held_pixel <= in_data;
    if (unit_done) begin
      case (state)
        scrg_pkg::ST_FY: work <= (64'(held_pixel.pixel_y) << 24) + res;
        scrg_pkg::ST_FX: work <= (64'(held_pixel.pixel_x) << 24) + res;
        scrg_pkg::ST_TY: begin
          ny <= t_rnd > scrg_pkg::ONE_Q24;
          work <= (t_rnd > scrg_pkg::ONE_Q24) ? t_rnd - scrg_pkg::ONE_Q24
                                              : scrg_pkg::ONE_Q24 - t_rnd;
        end
        scrg_pkg::ST_TX: begin
          nx <= t_rnd < asp;
          work <= (t_rnd < asp) ? asp - t_rnd : t_rnd - asp;
        end
        scrg_pkg::ST_DY: dy <= d_sat;
        scrg_pkg::ST_DX: dx <= d_sat;
        scrg_pkg::ST_SQX: sq <= res;
        scrg_pkg::ST_SQY: sq <= sq + res + scrg_pkg::ONE_Q32;
        scrg_pkg::ST_ROOT: q <= res[30:0];
        scrg_pkg::ST_CX: cx <= scrg_pkg::unit_comp(res, nx);
        scrg_pkg::ST_CY: cy <= scrg_pkg::unit_comp(res, ny);
        scrg_pkg::ST_CZ: cz <= scrg_pkg::unit_comp(res, 1'b1);
        default: q <= q;
      endcase
    end
    if (state == scrg_pkg::ST_EMIT && (!out_valid || out_ready)) begin
      out_data.dir_x <= cx;
      out_data.dir_y <= cy;
      out_data.dir_z <= cz;
      out_data.last_ray <= row_end && col_end;
    end
  end

  // checks
  a_dir_z_nonpos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.dir_z[15] || out_data.dir_z == 16'sd0))
    else $error("dir_z positive");

  a_start_idle_unit: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !unit_busy)
    else $error("unit started while busy");

  a_accept_at_origin: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> (sub_row == '0 && sub_column == '0))
    else $error("new pixel accepted mid grid");

endmodule

### hw/rtl/scrg_unit.sv
// shared iterative unit: shift-add multiply, restoring divide, bit-serial square root
module scrg_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  scrg_pkg::unit_req_t      req,
  output logic                     busy,
  output logic                     done,
  output logic [scrg_pkg::WORD_W-1:0] result
);

  scrg_pkg::op_t op;
  logic [63:0] acc;
  logic [63:0] opa;
  logic [63:0] opb;
  logic [scrg_pkg::STEP_CNT_W-1:0] cnt;
  logic [scrg_pkg::STEP_CNT_W-1:0] last_cnt;
  logic [63:0] rem_sh;
  logic [63:0] trial;

  // step datapath terms
  assign rem_sh = {acc[62:0], opa[scrg_pkg::DIV_STEPS-1]};
  assign trial = opa + opb;

  always_comb begin
    case (op)
      scrg_pkg::OP_MUL: last_cnt = scrg_pkg::STEP_CNT_W'(scrg_pkg::MUL_STEPS - 1);
      scrg_pkg::OP_DIV: last_cnt = scrg_pkg::STEP_CNT_W'(scrg_pkg::DIV_STEPS - 1);
      scrg_pkg::OP_ROOT: last_cnt = scrg_pkg::STEP_CNT_W'(scrg_pkg::ROOT_STEPS - 1);
      default: last_cnt = '0;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == last_cnt) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operand and accumulator registers
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      op <= req.op;
      case (req.op)
        scrg_pkg::OP_MUL: begin
          acc <= '0;
          opa <= req.a;
          opb <= req.b;
        end
        scrg_pkg::OP_DIV: begin
          acc <= '0;
          opa <= req.a;
          opb <= req.b;
        end
        scrg_pkg::OP_ROOT: begin
          acc <= req.a;
          opa <= '0;
          opb <= scrg_pkg::ROOT_BIT_INIT;
        end
        default: begin
          acc <= '0;
          opa <= '0;
          opb <= '0;
        end
      endcase
    end else if (busy) begin
      case (op)
        scrg_pkg::OP_MUL: begin
          if (opb[0]) acc <= acc + opa;
          opa <= {opa[62:0], 1'b0};
          opb <= {1'b0, opb[63:1]};
        end
        scrg_pkg::OP_DIV: begin
          if (rem_sh >= opb) begin
            acc <= rem_sh - opb;
            opa <= {opa[62:0], 1'b1};
          end else begin
            acc <= rem_sh;
            opa <= {opa[62:0], 1'b0};
          end
        end
        scrg_pkg::OP_ROOT: begin
          if (acc >= trial) begin
            acc <= acc - trial;
            opa <= {1'b0, opa[63:1]} + opb;
          end else begin
            opa <= {1'b0, opa[63:1]};
          end
          opb <= {2'b00, opb[63:2]};
        end
        default: begin
          acc <= acc;
        end
      endcase
    end
  end

  // result select
  always_comb begin
    case (op)
      scrg_pkg::OP_MUL: result = acc;
      scrg_pkg::OP_DIV: result = {16'd0, opa[scrg_pkg::DIV_STEPS-1:0]};
      scrg_pkg::OP_ROOT: result = opa;
      default: result = '0;
    endcase
  end

endmodule
